// ----- rtl/dsa_pkg.sv -----
// Package for the DSA sign and verify block: widths, reset values and state codes.
// Used by the interfaces, the modular arithmetic unit and the top level.
package dsa_pkg;

    localparam int MOD_BITS_DEF = 31;
    localparam int REG_WIDTH    = 31;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PRIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GEN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY   = 2'd3;

    localparam logic [REG_WIDTH-1:0] RST_PRIME = 31'd23;
    localparam logic [REG_WIDTH-1:0] RST_ORDER = 31'd11;
    localparam logic [REG_WIDTH-1:0] RST_GEN   = 31'd4;
    localparam logic [REG_WIDTH-1:0] RST_KEY   = 31'd3;

    // Operations of the shared serial arithmetic unit.
    typedef enum logic [1:0] {
        t_OP_MULMOD = 2'd0,
        t_OP_DIVMOD = 2'd1
    } t_alu_op;

    // Top level sequencer states.
    typedef enum logic [4:0] {
        t_ST_IDLE,
        t_ST_INIT,
        t_ST_EXP_STEP,
        t_ST_EXP_MUL,
        t_ST_EXP_SQR,
        t_ST_EXP_DONE,
        t_ST_RRED,
        t_ST_XR,
        t_ST_S1,
        t_ST_KRED,
        t_ST_EUC_CHK,
        t_ST_EUC_DIV,
        t_ST_EUC_T,
        t_ST_EUC_END,
        t_ST_S,
        t_ST_U1,
        t_ST_U2,
        t_ST_VMUL,
        t_ST_VRED,
        t_ST_OUT
    } t_state;

    // Request to the arithmetic unit.
    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

endpackage

// ----- rtl/dsa_in_if.sv -----
// Input channel interface: message hash and nonce with valid/ready.
// Depends on dsa_pkg.
interface dsa_in_if
    import dsa_pkg::*;
#(
    parameter int W = MOD_BITS_DEF
);
    logic         valid;
    logic         ready;
    logic [W-1:0] message_hash;
    logic [W-1:0] nonce;

    modport source (output valid, message_hash, nonce, input ready);
    modport sink (input valid, message_hash, nonce, output ready);
endinterface

// ----- rtl/dsa_out_if.sv -----
// Output channel interface: the full signature and verification word.
// Depends on dsa_pkg.
interface dsa_out_if
    import dsa_pkg::*;
#(
    parameter int W = MOD_BITS_DEF
);
    logic         valid;
    logic         ready;
    logic [W-1:0] public_key;
    logic [W-1:0] sig_r;
    logic [W-1:0] sig_s;
    logic [W-1:0] inverse_of_nonce;
    logic [W-1:0] exponent_one;
    logic [W-1:0] exponent_two;
    logic [W-1:0] check_value;
    logic         signature_valid;
    logic         no_inverse;

    modport source (output valid, public_key, sig_r, sig_s, inverse_of_nonce, exponent_one,
                    exponent_two, check_value, signature_valid, no_inverse, input ready);
    modport sink (input valid, public_key, sig_r, sig_s, inverse_of_nonce, exponent_one,
                  exponent_two, check_value, signature_valid, no_inverse, output ready);
endinterface

// ----- rtl/dsa_alu.sv -----
// Bit-serial modular arithmetic unit: (a*b) mod m and a divided by m (quotient, remainder).
// Depends on dsa_pkg. One bit of the operand is processed per cycle.
module dsa_alu
    import dsa_pkg::*;
#(
    parameter int W = MOD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_alu_req     i_req,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_m,
    output logic         o_done,
    output logic [W-1:0] o_res,
    output logic [W-1:0] o_quo
);
    localparam int CW = $clog2(W + 1);

    // Accumulator one bit wider than the modulus; 2*acc before reduction is formed in dbl.
    logic [W:0]    r_acc, n_acc;
    logic [W-1:0]  r_sh, n_sh;
    logic [W-1:0]  r_b, n_b;
    logic [W-1:0]  r_m, n_m;
    logic [W-1:0]  r_quo, n_quo;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    t_alu_op       r_op, n_op;

    logic [W+1:0] dbl;
    logic [W+1:0] add;
    logic [W+1:0] sub1;
    logic [W+1:0] red;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_sh  <= n_sh;
        r_b   <= n_b;
        r_m   <= n_m;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
        r_op  <= n_op;
    end

    // One shift-and-add (multiply) or shift-and-subtract (divide) step per cycle.
    always_comb begin
        n_acc  = r_acc;
        n_sh   = r_sh;
        n_b    = r_b;
        n_m    = r_m;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_op   = r_op;
        n_busy = r_busy;
        n_done = 1'b0;
        dbl    = {r_acc, 1'b0};
        add    = '0;
        sub1   = '0;
        red    = '0;
        if (i_req.start) begin
            n_acc  = '0;
            n_sh   = i_a;
            n_b    = (i_req.op == t_OP_MULMOD) ? i_b : '0;
            n_m    = i_m;
            n_quo  = '0;
            n_cnt  = CW'(W);
            n_op   = i_req.op;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_m == '0) begin
                n_acc  = '0;
                n_quo  = '0;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                if (r_op == t_OP_MULMOD) begin
                    // acc and b stay below m, so 2*acc+b < 3m and two subtracts bring it below m.
                    add  = dbl + (r_sh[W-1] ? {2'b00, r_b} : '0);
                    sub1 = (add >= {2'b00, r_m}) ? add - {2'b00, r_m} : add;
                    red  = (sub1 >= {2'b00, r_m}) ? sub1 - {2'b00, r_m} : sub1;
                    n_acc = red[W:0];
                    n_quo = r_quo;
                end else begin
                    add  = dbl | {{(W+1){1'b0}}, r_sh[W-1]};
                    red  = (add >= {2'b00, r_m}) ? add - {2'b00, r_m} : add;
                    n_acc = red[W:0];
                    n_quo = {r_quo[W-2:0], (add >= {2'b00, r_m})};
                end
                n_sh  = {r_sh[W-2:0], 1'b0};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc[W-1:0];
    assign o_quo  = r_quo;
endmodule

// ----- rtl/dsa_sign_and_verify.sv -----
// DSA sign and verify over moduli of up to MOD_BITS bits, one word at a time.
// Every multiply and divide runs on one shared bit-serial unit. A word takes four exponentiations,
// each a base reduction, then MOD_BITS squarings and one multiply per set exponent bit; the Euclid
// steps, each one divide and one multiply; and nine other operations. The next word is taken
// only after the result word is accepted. Synchronous active-low reset sets p=23, q=11, g=4, x=3.
module dsa_sign_and_verify
    import dsa_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_WIDTH-1:0] i_cfg_data,
    dsa_in_if.sink               in_ch,
    dsa_out_if.source            out_ch
);
    localparam int W  = MOD_BITS;
    localparam int EW = $clog2(W + 1);

    // Configuration registers.
    logic [W-1:0] r_p, r_q, r_g, r_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= RST_PRIME[W-1:0];
            r_q <= RST_ORDER[W-1:0];
            r_g <= RST_GEN[W-1:0];
            r_x <= RST_KEY[W-1:0];
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PRIME: r_p <= i_cfg_data[W-1:0];
                CFG_ORDER: r_q <= i_cfg_data[W-1:0];
                CFG_GEN:   r_g <= i_cfg_data[W-1:0];
                CFG_KEY:   r_x <= i_cfg_data[W-1:0];
                default: ;
            endcase
        end
    end

    t_state r_st, n_st;
    logic [1:0] r_eidx, n_eidx;     // which exponentiation: 0 y, 1 g^k, 2 g^u1, 3 y^u2
    logic [W-1:0] r_hm, n_hm, r_k, n_k;
    logic [W-1:0] r_y, n_y, r_r, n_r, r_s, n_s, r_w, n_w;
    logic [W-1:0] r_u1, n_u1, r_u2, n_u2, r_v, n_v, r_v1, n_v1;
    logic [W-1:0] r_xr, n_xr;
    logic [W-1:0] r_acc, n_acc, r_base, n_base, r_exp, n_exp;
    logic [EW-1:0] r_ecnt, n_ecnt;
    logic [W-1:0] r_r0, n_r0, r_r1, n_r1, r_t0, n_t0, r_t1, n_t1, r_qq, n_qq;
    logic r_none, n_none, r_wait, n_wait;
    logic r_ovalid, n_ovalid;

    t_alu_req     alu_req;
    logic [W-1:0] alu_a, alu_b, alu_m, alu_res, alu_quo;
    logic         alu_done;

    dsa_alu #(.W(W)) u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (alu_req),
        .i_a    (alu_a),
        .i_b    (alu_b),
        .i_m    (alu_m),
        .o_done (alu_done),
        .o_res  (alu_res),
        .o_quo  (alu_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= t_ST_IDLE;
            r_ovalid <= 1'b0;
            r_wait   <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_ovalid <= n_ovalid;
            r_wait   <= n_wait;
        end
        r_eidx <= n_eidx;
        r_hm <= n_hm; r_k <= n_k; r_y <= n_y; r_r <= n_r; r_s <= n_s; r_w <= n_w;
        r_u1 <= n_u1; r_u2 <= n_u2; r_v <= n_v; r_v1 <= n_v1; r_xr <= n_xr;
        r_acc <= n_acc; r_base <= n_base; r_exp <= n_exp; r_ecnt <= n_ecnt;
        r_r0 <= n_r0; r_r1 <= n_r1; r_t0 <= n_t0; r_t1 <= n_t1; r_qq <= n_qq;
        r_none <= n_none;
    end

    // Modular subtraction t0 - qq*t1 (mod q) uses the unit's product in alu_res.
    logic [W-1:0] one_p, sum_hm;
    logic [W:0]   sum_wide, diff_wide;

    always_comb begin
        n_st = r_st; n_eidx = r_eidx; n_hm = r_hm; n_k = r_k; n_y = r_y; n_r = r_r;
        n_s = r_s; n_w = r_w; n_u1 = r_u1; n_u2 = r_u2; n_v = r_v; n_v1 = r_v1;
        n_xr = r_xr; n_acc = r_acc; n_base = r_base; n_exp = r_exp; n_ecnt = r_ecnt;
        n_r0 = r_r0; n_r1 = r_r1; n_t0 = r_t0; n_t1 = r_t1; n_qq = r_qq;
        n_none = r_none; n_ovalid = r_ovalid; n_wait = 1'b0;
        alu_req.start = 1'b0; alu_req.op = t_OP_MULMOD;
        alu_a = '0; alu_b = '0; alu_m = r_p;
        one_p = (r_p == W'(1)) ? '0 : ((r_p == '0) ? '0 : W'(1));
        sum_wide = '0; diff_wide = '0; sum_hm = '0;
        if (out_ch.ready) n_ovalid = 1'b0;
        case (r_st)
            t_ST_IDLE: begin
                if (in_ch.valid && !r_ovalid) begin
                    n_hm = in_ch.message_hash; n_k = in_ch.nonce;
                    n_eidx = 2'd0; n_st = t_ST_INIT;
                end
            end
            // Load base and exponent for the selected exponentiation; reduce base.
            t_ST_INIT: begin
                if (!r_wait) begin
                    alu_req.start = 1'b1; alu_req.op = t_OP_DIVMOD;
                    alu_a = (r_eidx == 2'd3) ? r_y : r_g; alu_m = r_p; n_wait = 1'b1;
                    case (r_eidx)
                        2'd0: n_exp = r_x;
                        2'd1: n_exp = r_k;
                        2'd2: n_exp = r_u1;
                        default: n_exp = r_u2;
                    endcase
                end else if (alu_done) begin
                    n_base = alu_res; n_acc = one_p; n_ecnt = EW'(W); n_st = t_ST_EXP_STEP;
                end else n_wait = 1'b1;
            end
            t_ST_EXP_STEP: begin
                if (r_ecnt == '0) n_st = t_ST_EXP_DONE;
                else if (r_exp[0]) n_st = t_ST_EXP_MUL;
                else n_st = t_ST_EXP_SQR;
            end
            t_ST_EXP_MUL: begin
                if (!r_wait) begin
                    alu_req.start = 1'b1; alu_a = r_acc; alu_b = r_base; n_wait = 1'b1;
                end else if (alu_done) begin
                    n_acc = alu_res; n_st = t_ST_EXP_SQR;
                end else n_wait = 1'b1;
            end
            t_ST_EXP_SQR: begin
                if (!r_wait) begin
                    alu_req.start = 1'b1; alu_a = r_base; alu_b = r_base; n_wait = 1'b1;
                end else if (alu_done) begin
                    n_base = alu_res; n_exp = r_exp >> 1; n_ecnt = r_ecnt - EW'(1);
                    n_st = t_ST_EXP_STEP;
                end else n_wait = 1'b1;
            end
            t_ST_EXP_DONE: begin
                case (r_eidx)
                    2'd0: begin n_y = r_acc; n_eidx = 2'd1; n_st = t_ST_INIT; end
                    2'd1: n_st = t_ST_RRED;
                    2'd2: begin n_v1 = r_acc; n_eidx = 2'd3; n_st = t_ST_INIT; end
                    default: n_st = t_ST_VMUL;
                endcase
            end
            // r = (g^k mod p) mod q.
            t_ST_RRED: begin
                if (!r_wait) begin
                    alu_req.start = 1'b1; alu_req.op = t_OP_DIVMOD;
                    alu_a = r_acc; alu_m = r_q; n_wait = 1'b1;
                end else if (alu_done) begin
                    n_r = alu_res; n_st = t_ST_XR;
                end else n_wait = 1'b1;
            end
            t_ST_XR: begin
                if (!r_wait) begin
                    alu_req.start = 1'b1; alu_a = r_x; alu_b = r_r; alu_m = r_q;
                    n_wait = 1'b1;
                end else if (alu_done) begin
                    n_xr = alu_res; n_st = t_ST_S1;
                end else n_wait = 1'b1;
            end
            // s1 = (hm + x*r) mod q, with hm reduced first.
            t_ST_S1: begin
                if (!r_wait) begin
                    alu_req.start = 1'b1; alu_req.op = t_OP_DIVMOD;
                    alu_a = r_hm; alu_m = r_q; n_wait = 1'b1;
                end else if (alu_done) begin
                    sum_wide = {1'b0, alu_res} + {1'b0, r_xr};
                    sum_hm = (sum_wide >= {1'b0, r_q}) ? W'(sum_wide - {1'b0, r_q})
                                                        : sum_wide[W-1:0];
                    n_xr = sum_hm; n_st = t_ST_KRED;
                end else n_wait = 1'b1;
            end
            // Extended Euclid start: r0=q, r1=k mod q, t0=0, t1=1.
            t_ST_KRED: begin
                if (!r_wait) begin
                    alu_req.start = 1'b1; alu_req.op = t_OP_DIVMOD;
                    alu_a = r_k; alu_m = r_q; n_wait = 1'b1;
                end else if (alu_done) begin
                    n_r0 = r_q; n_r1 = alu_res; n_t0 = '0; n_t1 = W'(1);
                    n_st = t_ST_EUC_CHK;
                end else n_wait = 1'b1;
            end
            t_ST_EUC_CHK: begin
                if (r_q == '0 || r_q == W'(1) || r_r1 == '0) n_st = t_ST_EUC_END;
                else n_st = t_ST_EUC_DIV;
            end
            t_ST_EUC_DIV: begin
                if (!r_wait) begin
                    alu_req.start = 1'b1; alu_req.op = t_OP_DIVMOD;
                    alu_a = r_r0; alu_m = r_r1; n_wait = 1'b1;
                end else if (alu_done) begin
                    n_qq = alu_quo; n_r0 = r_r1; n_r1 = alu_res; n_st = t_ST_EUC_T;
                end else n_wait = 1'b1;
            end
            // t kept mod q: t_new = t0 - (qq mod q)*t1 mod q.
            t_ST_EUC_T: begin
                if (!r_wait) begin
                    alu_req.start = 1'b1; alu_a = r_qq; alu_b = r_t1; alu_m = r_q;
                    n_wait = 1'b1;
                end else if (alu_done) begin
                    diff_wide = {1'b0, r_t0} - {1'b0, alu_res};
                    if (r_t0 >= alu_res) n_t1 = W'(diff_wide);
                    else n_t1 = W'(diff_wide + {1'b0, r_q});
                    n_t0 = r_t1; n_st = t_ST_EUC_CHK;
                end else n_wait = 1'b1;
            end
            t_ST_EUC_END: begin
                if (r_q == '0) begin
                    n_none = 1'b1; n_w = '0;
                end else if (r_q == W'(1)) begin
                    n_none = 1'b0; n_w = '0;
                end else if (r_r0 != W'(1)) begin
                    n_none = 1'b1; n_w = '0;
                end else begin
                    n_none = 1'b0; n_w = r_t0;
                end
                n_st = t_ST_S;
            end
            t_ST_S: begin
                if (!r_wait) begin
                    alu_req.start = 1'b1; alu_a = r_w; alu_b = r_xr; alu_m = r_q;
                    n_wait = 1'b1;
                end else if (alu_done) begin
                    n_s = alu_res; n_st = t_ST_U1;
                end else n_wait = 1'b1;
            end
            t_ST_U1: begin
                if (!r_wait) begin
                    alu_req.start = 1'b1; alu_a = r_hm; alu_b = r_w; alu_m = r_q;
                    n_wait = 1'b1;
                end else if (alu_done) begin
                    n_u1 = alu_res; n_st = t_ST_U2;
                end else n_wait = 1'b1;
            end
            t_ST_U2: begin
                if (!r_wait) begin
                    alu_req.start = 1'b1; alu_a = r_r; alu_b = r_w; alu_m = r_q;
                    n_wait = 1'b1;
                end else if (alu_done) begin
                    n_u2 = alu_res; n_eidx = 2'd2; n_st = t_ST_INIT;
                end else n_wait = 1'b1;
            end
            t_ST_VMUL: begin
                if (!r_wait) begin
                    alu_req.start = 1'b1; alu_a = r_v1; alu_b = r_acc; alu_m = r_p;
                    n_wait = 1'b1;
                end else if (alu_done) begin
                    n_v = alu_res; n_st = t_ST_VRED;
                end else n_wait = 1'b1;
            end
            t_ST_VRED: begin
                if (!r_wait) begin
                    alu_req.start = 1'b1; alu_req.op = t_OP_DIVMOD;
                    alu_a = r_v; alu_m = r_q; n_wait = 1'b1;
                end else if (alu_done) begin
                    n_v = alu_res; n_st = t_ST_OUT;
                end else n_wait = 1'b1;
            end
            t_ST_OUT: begin
                n_ovalid = 1'b1; n_st = t_ST_IDLE;
            end
            default: n_st = t_ST_IDLE;
        endcase
    end

    // The result word is read straight from the working registers, which hold still
    // while the sequencer idles with a pending result.
    assign in_ch.ready             = (r_st == t_ST_IDLE) && !r_ovalid;
    assign out_ch.valid            = r_ovalid;
    assign out_ch.public_key       = r_y;
    assign out_ch.sig_r            = r_r;
    assign out_ch.sig_s            = r_s;
    assign out_ch.inverse_of_nonce = r_w;
    assign out_ch.exponent_one     = r_u1;
    assign out_ch.exponent_two     = r_u2;
    assign out_ch.check_value      = r_v;
    assign out_ch.signature_valid  = (r_v == r_r);
    assign out_ch.no_inverse       = r_none;

`ifndef NO_ASSERTIONS
    // No new word is taken while a result is still pending.
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("input ready while result pending");
    // A result is raised only from the final sequencer step.
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_ch.valid) |-> $past(r_st) == t_ST_OUT) else $error("stray result");
    // The arithmetic unit is never restarted while a wait is outstanding.
    a_alu_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_req.start |-> !r_wait) else $error("unit restarted while busy");
`endif
endmodule
